// ===== rtl/pfrgba_pkg.sv =====
// Package for the pattern file to RGBA decoder: constants, status codes and
// the captured header record. No dependencies.
`timescale 1ns / 1ps

package pfrgba_pkg;

  // Fixed header geometry and identification.
  localparam int unsigned HdrBytes  = 24;
  localparam logic [31:0] MagicGpat = 32'h4750_4154;
  localparam logic [31:0] VersionOne = 32'd1;

  // Configuration port geometry and reset values.
  localparam int unsigned MaxSideW  = 32;
  localparam int unsigned MaxPixW   = 41;
  localparam int unsigned CfgDataW  = 41;
  localparam int unsigned CfgIdxW   = 1;
  localparam logic [MaxSideW-1:0] MaxSideRst = 32'd524288;
  localparam logic [MaxPixW-1:0]  MaxPixRst  = 41'd268435456;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_SIDE   = 1'b0,
    CFG_MAX_PIXELS = 1'b1
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_INVALID = 2'd2,
    ST_LARGE   = 2'd3
  } status_e;

  // Header words as captured from the file.
  typedef struct packed {
    logic [31:0] hlen;
    logic [31:0] version;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] depth;
    logic [31:0] magic;
  } hdr_t;

endpackage

// ===== rtl/pfrgba_if.sv =====
// Stream interfaces of the pattern decoder: file bytes in, RGBA results out.
// Depends on nothing but the valid/ready handshake convention.
`timescale 1ns / 1ps

interface pfrgba_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface pfrgba_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        pixel_valid;
  logic [1:0]  status;
  logic        final_result;
  logic [31:0] image_width;
  logic [31:0] image_height;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output pixel_valid, output status, output final_result,
                  output image_width, output image_height, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input pixel_valid, input status, input final_result,
                  input image_width, input image_height, output ready);
endinterface

// ===== rtl/pattern_file_to_rgba_unit.sv =====
// Top level of the pattern file to RGBA decoder.
// Uses pfrgba_pkg, the pfrgba_byte_if / pfrgba_pix_if interfaces and pfrgba_hdr_check.
`timescale 1ns / 1ps

// The decoder takes one file byte per transfer and accepts a byte in every
// cycle; each byte passes through one stage of logic into the result register,
// so a result appears in the cycle after the byte that causes it. The result
// register is backed by the ready of the output channel: the input stalls only
// while a finished result waits there and the consumer is not ready. Header
// words are captured big-endian; after the 24th byte one result with an
// invalid or too-large status ends a rejected file. Pixels are sent as they
// complete, before the end of the file is seen, so on a truncated status the
// consumer must discard every pixel of that file. A byte with end_of_file set
// returns the decoder to the start of a new file. The user writes the size limits
// through the configuration port only while the decoder is idle; the block does not enforce it.

module pattern_file_to_rgba_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pfrgba_byte_if.sink                         byte_i,
  pfrgba_pix_if.source                        pix_o,
  input  logic                                cfg_we_i,
  input  logic [pfrgba_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [pfrgba_pkg::CfgDataW-1:0]     cfg_data_i
);

  // Decoder phases.
  localparam logic [1:0] PhHeader = 2'd0;
  localparam logic [1:0] PhSkip   = 2'd1;
  localparam logic [1:0] PhPixels = 2'd2;
  localparam logic [1:0] PhDrain  = 2'd3;

  logic [pfrgba_pkg::MaxSideW-1:0] max_side_q;
  logic [pfrgba_pkg::MaxPixW-1:0]  max_pixels_q;

  logic [1:0]        phase_q, phase_d;
  logic [31:0]       bytepos_q, bytepos_d;
  pfrgba_pkg::hdr_t  hdr_q, hdr_d, hdr_nx;
  logic [40:0]       pix_left_q, pix_left_d;
  logic [23:0]       partial_q, partial_d;
  logic [1:0]        bip_q, bip_d;

  logic [pfrgba_pkg::MaxPixW-1:0] area;
  pfrgba_pkg::status_e  chk_status;

  logic        accept;
  logic [7:0]  in_byte;
  logic        in_eof;
  logic [31:0] byte_sh;

  // Result produced by the current byte.
  logic                 em;
  logic                 em_pvalid;
  pfrgba_pkg::status_e  em_status;
  logic                 em_final;
  logic [7:0]           px_r, px_g, px_b, px_a;
  logic [7:0]           v0, v1, v2, v3;
  logic [2:0]           depth;
  logic                 restart;

  // Output register.
  logic                 out_valid_q;
  logic [7:0]           r_q, g_q, b_q, a_q;
  logic                 pvalid_q;
  pfrgba_pkg::status_e  status_q;
  logic                 final_q;
  logic [31:0]          width_q, height_q;

  assign in_byte = byte_i.data_byte;
  assign in_eof  = byte_i.end_of_file;
  assign byte_i.ready = !out_valid_q || pix_o.ready;
  assign accept = byte_i.valid && byte_i.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_side_q   <= pfrgba_pkg::MaxSideRst;
      max_pixels_q <= pfrgba_pkg::MaxPixRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfrgba_pkg::CFG_MAX_SIDE:   max_side_q   <= cfg_data_i[pfrgba_pkg::MaxSideW-1:0];
        pfrgba_pkg::CFG_MAX_PIXELS: max_pixels_q <= cfg_data_i[pfrgba_pkg::MaxPixW-1:0];
        default: ;
      endcase
    end
  end

  // Header capture: the byte lands in its big-endian lane of the current word.
  always_comb begin
    hdr_nx  = hdr_q;
    byte_sh = {24'd0, in_byte} << {~bytepos_q[1:0], 3'b000};
    if (phase_q == PhHeader) begin
      case (bytepos_q[4:2])
        3'd0:    hdr_nx.hlen    = hdr_q.hlen | byte_sh;
        3'd1:    hdr_nx.version = hdr_q.version | byte_sh;
        3'd2:    hdr_nx.width   = hdr_q.width | byte_sh;
        3'd3:    hdr_nx.height  = hdr_q.height | byte_sh;
        3'd4:    hdr_nx.depth   = hdr_q.depth | byte_sh;
        default: hdr_nx.magic   = hdr_q.magic | byte_sh;
      endcase
    end
  end

  pfrgba_hdr_check u_hdr_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hdr_i        (hdr_nx),
    .max_side_i   (max_side_q),
    .max_pixels_i (max_pixels_q),
    .area_o       (area),
    .status_o     (chk_status)
  );

  // Pixel assembly: earlier bytes sit in the partial word, the current byte
  // takes the lane of its position within the pixel.
  always_comb begin
    depth = hdr_q.depth[2:0];
    v0 = partial_q[23:16];
    v1 = partial_q[15:8];
    v2 = partial_q[7:0];
    v3 = 8'd0;
    case (bip_q)
      2'd0:    v0 = in_byte;
      2'd1:    v1 = in_byte;
      2'd2:    v2 = in_byte;
      default: v3 = in_byte;
    endcase
    if (depth <= 3'd2) begin
      px_r = v0;
      px_g = v0;
      px_b = v0;
      px_a = (depth == 3'd2) ? v1 : 8'hFF;
    end else begin
      px_r = v0;
      px_g = v1;
      px_b = v2;
      px_a = (depth == 3'd4) ? v3 : 8'hFF;
    end
  end

  // Decoder step for one accepted byte.
  always_comb begin
    phase_d    = phase_q;
    bytepos_d  = bytepos_q;
    hdr_d      = hdr_nx;
    pix_left_d = pix_left_q;
    partial_d  = partial_q;
    bip_d      = bip_q;
    em         = 1'b0;
    em_pvalid  = 1'b0;
    em_status  = pfrgba_pkg::ST_OK;
    em_final   = 1'b0;
    restart    = 1'b0;

    case (phase_q)
      PhHeader: begin
        bytepos_d = bytepos_q + 32'd1;
        if (bytepos_d == 32'(pfrgba_pkg::HdrBytes)) begin
          if (chk_status != pfrgba_pkg::ST_OK) begin
            em        = 1'b1;
            em_status = chk_status;
            em_final  = 1'b1;
            restart   = in_eof;
            phase_d   = PhDrain;
          end else begin
            pix_left_d = area;
            phase_d    = PhSkip;
            if (in_eof) begin
              em        = 1'b1;
              em_status = pfrgba_pkg::ST_TRUNC;
              em_final  = 1'b1;
              restart   = 1'b1;
            end
          end
        end else if (in_eof) begin
          em        = 1'b1;
          em_status = pfrgba_pkg::ST_TRUNC;
          em_final  = 1'b1;
          restart   = 1'b1;
        end
      end
      PhSkip: begin
        bytepos_d = bytepos_q + 32'd1;
        if (bytepos_d == hdr_q.hlen) begin
          phase_d = PhPixels;
        end
        if (in_eof) begin
          em        = 1'b1;
          em_status = pfrgba_pkg::ST_TRUNC;
          em_final  = 1'b1;
          restart   = 1'b1;
        end
      end
      PhPixels: begin
        if (({1'b0, bip_q} + 3'd1) < depth) begin
          case (bip_q)
            2'd0:    partial_d = partial_q | {in_byte, 16'd0};
            2'd1:    partial_d = partial_q | {8'd0, in_byte, 8'd0};
            default: partial_d = partial_q | {16'd0, in_byte};
          endcase
          bip_d = bip_q + 2'd1;
          if (in_eof) begin
            em        = 1'b1;
            em_status = pfrgba_pkg::ST_TRUNC;
            em_final  = 1'b1;
            restart   = 1'b1;
          end
        end else begin
          bip_d      = 2'd0;
          partial_d  = '0;
          pix_left_d = pix_left_q - 41'd1;
          if (pix_left_q == 41'd1) begin
            // Last pixel of the image.
            em        = 1'b1;
            em_pvalid = 1'b1;
            em_final  = 1'b1;
            restart   = in_eof;
            phase_d   = PhDrain;
          end else if (!in_eof) begin
            em        = 1'b1;
            em_pvalid = 1'b1;
          end else begin
            // End of file inside the image: the completed pixel is dropped.
            em        = 1'b1;
            em_status = pfrgba_pkg::ST_TRUNC;
            em_final  = 1'b1;
            restart   = 1'b1;
          end
        end
      end
      default: begin
        restart = in_eof;
      end
    endcase

    if (restart) begin
      phase_d    = PhHeader;
      bytepos_d  = '0;
      hdr_d      = '0;
      pix_left_d = '0;
      partial_d  = '0;
      bip_d      = '0;
    end
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      bytepos_q  <= '0;
      hdr_q      <= '0;
      pix_left_q <= '0;
      partial_q  <= '0;
      bip_q      <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      bytepos_q  <= bytepos_d;
      hdr_q      <= hdr_d;
      pix_left_q <= pix_left_d;
      partial_q  <= partial_d;
      bip_q      <= bip_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && em) begin
      out_valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; pixel channels read zero on a status-only result.
  always_ff @(posedge clk_i) begin
    if (accept && em) begin
      r_q      <= em_pvalid ? px_r : 8'd0;
      g_q      <= em_pvalid ? px_g : 8'd0;
      b_q      <= em_pvalid ? px_b : 8'd0;
      a_q      <= em_pvalid ? px_a : 8'd0;
      pvalid_q <= em_pvalid;
      status_q <= em_status;
      final_q  <= em_final;
      width_q  <= hdr_nx.width;
      height_q <= hdr_nx.height;
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.red          = r_q;
  assign pix_o.green        = g_q;
  assign pix_o.blue         = b_q;
  assign pix_o.alpha        = a_q;
  assign pix_o.pixel_valid  = pvalid_q;
  assign pix_o.status       = status_q;
  assign pix_o.final_result = final_q;
  assign pix_o.image_width  = width_q;
  assign pix_o.image_height = height_q;

endmodule

// ===== rtl/pfrgba_hdr_check.sv =====
// Header checker: validates the captured header and tests it against limits.
// Uses pfrgba_pkg for the header record, the magic word and status codes.
`timescale 1ns / 1ps

module pfrgba_hdr_check (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pfrgba_pkg::hdr_t                    hdr_i,
  input  logic [pfrgba_pkg::MaxSideW-1:0]     max_side_i,
  input  logic [pfrgba_pkg::MaxPixW-1:0]      max_pixels_i,
  output logic [pfrgba_pkg::MaxPixW-1:0]      area_o,
  output pfrgba_pkg::status_e                 status_o
);

  logic [63:0] area_q;
  logic        bad_fmt;
  logic        too_big;

  // The area is registered every cycle. Width and height are complete eight
  // bytes before the last header byte, so the product is settled by the check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= '0;
    end else begin
      area_q <= {32'd0, hdr_i.width} * {32'd0, hdr_i.height};
    end
  end

  // Format checks come first, then the size limits.
  always_comb begin
    bad_fmt = (hdr_i.magic != pfrgba_pkg::MagicGpat) ||
              (hdr_i.version != pfrgba_pkg::VersionOne) ||
              (hdr_i.hlen <= 32'(pfrgba_pkg::HdrBytes)) ||
              (hdr_i.depth == 32'd0) || (hdr_i.depth > 32'd4) ||
              (hdr_i.width == 32'd0) || (hdr_i.height == 32'd0);
    too_big = (hdr_i.width > max_side_i) || (hdr_i.height > max_side_i) ||
              (area_q > {23'd0, max_pixels_i});
    if (bad_fmt) begin
      status_o = pfrgba_pkg::ST_INVALID;
    end else if (too_big) begin
      status_o = pfrgba_pkg::ST_LARGE;
    end else begin
      status_o = pfrgba_pkg::ST_OK;
    end
  end

  // Only the low bits seed the pixel count; a larger area is rejected above.
  assign area_o = area_q[pfrgba_pkg::MaxPixW-1:0];

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for pattern_file_to_rgba_unit: streams pattern files
// byte by byte and checks every RGBA or status result against a local decoder.
// Depends on pfrgba_pkg, the pfrgba_byte_if / pfrgba_pix_if interfaces and the RTL.
`timescale 1ns / 1ps

module tb;
  import pfrgba_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ReportLimit = 10;

  // One byte of a file as offered on the input channel.
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        pixel_valid;
    status_e     status;
    logic        final_result;
    logic [31:0] width;
    logic [31:0] height;
  } rgba_result_t;

  // Parsing phases of the local decoder.
  typedef enum logic [2:0] {
    PARSE_HEADER,
    SKIP_HEADER,
    TAKE_PIXELS,
    DRAIN_FILE
  } parse_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_e cfg_idx = CFG_MAX_SIDE;
  logic [CfgDataW-1:0] cfg_data = '0;

  pfrgba_byte_if byte_if ();
  pfrgba_pix_if  pix_if ();

  pattern_file_to_rgba_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_if),
    .pix_o      (pix_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  file_byte_t   pending_bytes[$];
  rgba_result_t expected_rgba[$];
  int unsigned  bytes_queued = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  hold_cycles = 0;
  int unsigned  in_gap = 0;
  int unsigned  out_gap = 0;
  logic         gaps_on = 1'b1;
  logic         byte_accepted = 1'b0;

  // Local decoder state and its copy of the size limits.
  parse_phase_e phase_q;
  logic [31:0]  pos_q;
  hdr_t         hdr_q;
  logic [40:0]  left_q;
  logic [23:0]  partial_q;
  logic [1:0]   nbyte_q;
  logic [MaxSideW-1:0] max_side_q = MaxSideRst;
  logic [MaxPixW-1:0]  max_pix_q  = MaxPixRst;

  task automatic restart_decoder();
    phase_q   = PARSE_HEADER;
    pos_q     = '0;
    hdr_q     = '0;
    left_q    = '0;
    partial_q = '0;
    nbyte_q   = '0;
  endtask

  task automatic push_result(input logic [31:0] rgba, input logic valid, input status_e st,
                             input logic fin);
    rgba_result_t r;
    r.red          = valid ? rgba[31:24] : 8'd0;
    r.green        = valid ? rgba[23:16] : 8'd0;
    r.blue         = valid ? rgba[15:8]  : 8'd0;
    r.alpha        = valid ? rgba[7:0]   : 8'd0;
    r.pixel_valid  = valid;
    r.status       = st;
    r.final_result = fin;
    r.width        = hdr_q.width;
    r.height       = hdr_q.height;
    expected_rgba.push_back(r);
  endtask

  // Advances the local decoder by one file byte and queues the result it causes.
  task automatic decode_byte(input logic [7:0] b, input logic eof);
    logic [63:0] area;
    logic [7:0]  v [4];
    logic [31:0] rgba;
    int unsigned lane;
    int unsigned depth;
    status_e     st;
    case (phase_q)
      PARSE_HEADER: begin
        lane = 3 - pos_q[1:0];
        case (pos_q[4:2])
          3'd0:    hdr_q.hlen[8*lane +: 8] = b;
          3'd1:    hdr_q.version[8*lane +: 8] = b;
          3'd2:    hdr_q.width[8*lane +: 8] = b;
          3'd3:    hdr_q.height[8*lane +: 8] = b;
          3'd4:    hdr_q.depth[8*lane +: 8] = b;
          default: hdr_q.magic[8*lane +: 8] = b;
        endcase
        pos_q = pos_q + 1;
        if (pos_q == HdrBytes) begin
          area = {32'd0, hdr_q.width} * {32'd0, hdr_q.height};
          if (hdr_q.magic != MagicGpat || hdr_q.version != VersionOne ||
              hdr_q.hlen <= HdrBytes || hdr_q.depth < 1 || hdr_q.depth > 4 ||
              hdr_q.width == 0 || hdr_q.height == 0) begin
            st = ST_INVALID;
          end else if (hdr_q.width > max_side_q || hdr_q.height > max_side_q ||
                       area > {23'd0, max_pix_q}) begin
            st = ST_LARGE;
          end else begin
            st = ST_OK;
          end
          if (st != ST_OK) begin
            push_result('0, 1'b0, st, 1'b1);
            if (eof) restart_decoder();
            else phase_q = DRAIN_FILE;
            return;
          end
          left_q  = area[40:0];
          phase_q = SKIP_HEADER;
        end
      end
      SKIP_HEADER: begin
        pos_q = pos_q + 1;
        if (pos_q == hdr_q.hlen) phase_q = TAKE_PIXELS;
      end
      TAKE_PIXELS: begin
        depth = hdr_q.depth[2:0];
        if (nbyte_q + 1 < depth) begin
          case (nbyte_q)
            2'd0:    partial_q[23:16] = b;
            2'd1:    partial_q[15:8] = b;
            default: partial_q[7:0] = b;
          endcase
          nbyte_q = nbyte_q + 1;
        end else begin
          v[0] = partial_q[23:16];
          v[1] = partial_q[15:8];
          v[2] = partial_q[7:0];
          v[3] = 8'd0;
          v[nbyte_q] = b;
          // Grey and grey-alpha pixels spread the grey level over all colors.
          if (depth <= 2) rgba = {v[0], v[0], v[0], (depth == 2) ? v[1] : 8'hFF};
          else rgba = {v[0], v[1], v[2], (depth == 4) ? v[3] : 8'hFF};
          nbyte_q   = '0;
          partial_q = '0;
          left_q    = left_q - 41'd1;
          if (left_q == 0) begin
            push_result(rgba, 1'b1, ST_OK, 1'b1);
            if (eof) restart_decoder();
            else phase_q = DRAIN_FILE;
            return;
          end
          if (!eof) begin
            push_result(rgba, 1'b1, ST_OK, 1'b0);
            return;
          end
        end
      end
      default: begin
        if (eof) restart_decoder();
        return;
      end
    endcase
    // An end of file before the image is complete ends it as truncated.
    if (eof) begin
      push_result('0, 1'b0, ST_TRUNC, 1'b1);
      restart_decoder();
    end
  endtask

  // Queues one file: the header, then random body bytes, optionally cut short.
  task automatic queue_file(input hdr_t h, input int unsigned body_len,
                            input int unsigned cut);
    logic [191:0] hbits;
    int unsigned  total;
    file_byte_t   item;
    hbits = h;
    total = 24 + body_len;
    if (cut != 0 && cut < total) total = cut;
    for (int unsigned i = 0; i < total; i++) begin
      item.data = (i < 24) ? hbits[191-8*i -: 8] : 8'($urandom);
      item.eof  = (i == total - 1);
      pending_bytes.push_back(item);
      bytes_queued++;
    end
  endtask

  // Random files, mostly well formed, until the byte budget is spent.
  task automatic queue_random_files(input int unsigned budget);
    int unsigned start, w, ht, d, hl, body, kind;
    hdr_t h;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      kind = $urandom_range(0, 99);
      w    = $urandom_range(1, 4);
      ht   = $urandom_range(1, 4);
      if ($urandom_range(0, 15) == 0) begin
        w  = $urandom_range(1, 16);
        ht = $urandom_range(1, 64 / w);
      end
      d    = $urandom_range(1, 4);
      hl   = 24 + $urandom_range(1, 6);
      h    = hdr_t'{hl, VersionOne, w, ht, d, MagicGpat};
      body = hl - 24 + w * ht * d;
      if ($urandom_range(0, 1) == 1) body += $urandom_range(1, 3);
      if (kind < 70) begin
        queue_file(h, body, 0);
      end else if (kind < 85) begin
        queue_file(h, body, $urandom_range(1, 24 + body - 1));
      end else if (kind < 95) begin
        // Break one header field at a time.
        case ($urandom_range(0, 5))
          0: h.hlen = $urandom_range(0, 24);
          1: h.version = $urandom;
          2: h.width = '0;
          3: h.height = '0;
          4: h.depth = ($urandom_range(0, 1) == 1) ? 32'd0 : $urandom_range(5, 32'hFFFF_FFFF);
          default: h.magic = $urandom;
        endcase
        queue_file(h, $urandom_range(0, 6), 0);
      end else begin
        h = hdr_t'{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        queue_file(h, $urandom_range(0, 8), $urandom_range(1, 32));
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MAX_SIDE:   max_side_q = val[MaxSideW-1:0];
      default:        max_pix_q  = val[MaxPixW-1:0];
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Waits until every byte is taken and every result is in, then lets the
  // decoder settle on bytes that gave no result.
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_bytes.size() != 0 || byte_if.valid || expected_rgba.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic string show(input rgba_result_t r);
    return $sformatf("rgba=%02h%02h%02h%02h pv=%0b st=%0d fin=%0b w=%0h h=%0h",
                     r.red, r.green, r.blue, r.alpha, r.pixel_valid, r.status,
                     r.final_result, r.width, r.height);
  endfunction

  // Byte driver: a new transfer is offered once the previous one has gone.
  always @(negedge clk_i) begin : drive_bytes
    file_byte_t item;
    if (rst_ni && (!byte_if.valid || byte_accepted)) begin
      if (in_gap > 0) begin
        in_gap--;
        byte_if.valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        byte_if.valid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 15) == 0) begin
        in_gap = $urandom_range(1, 14) - 1;
        byte_if.valid <= 1'b0;
      end else begin
        item = pending_bytes.pop_front();
        byte_if.data_byte   <= item.data;
        byte_if.end_of_file <= item.eof;
        byte_if.valid       <= 1'b1;
      end
    end
  end

  // Result receiver: random stall bursts plus one long hold-off on request.
  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        pix_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        pix_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(1, 14) - 1;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: checks each result transfer, then feeds each byte transfer to
  // the local decoder.
  always @(posedge clk_i) begin : watch
    rgba_result_t got, want;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      got = {pix_if.red, pix_if.green, pix_if.blue, pix_if.alpha, pix_if.pixel_valid,
             status_e'(pix_if.status), pix_if.final_result, pix_if.image_width,
             pix_if.image_height};
      if (expected_rgba.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("%0t: unexpected result %s", $realtime, show(got));
      end else begin
        want = expected_rgba.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.alpha !== want.alpha ||
            got.pixel_valid !== want.pixel_valid || got.status !== want.status ||
            got.final_result !== want.final_result || got.width !== want.width ||
            got.height !== want.height) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                     show(want), show(got));
        end
      end
    end
    byte_accepted = rst_ni && byte_if.valid && byte_if.ready;
    if (byte_accepted) decode_byte(byte_if.data_byte, byte_if.end_of_file);
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    byte_if.valid       = 1'b0;
    byte_if.data_byte   = '0;
    byte_if.end_of_file = 1'b0;
    pix_if.ready        = 1'b0;
    restart_decoder();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits: every depth, every header fault, the size boundaries
    // and the various ways a file can end.
    queue_file(hdr_t'{25, VersionOne, 1, 1, 1, MagicGpat}, 2, 0);
    queue_file(hdr_t'{28, VersionOne, 2, 1, 2, MagicGpat}, 8, 0);
    queue_file(hdr_t'{25, VersionOne, 1, 2, 3, MagicGpat}, 10, 0);
    queue_file(hdr_t'{25, VersionOne, 2, 2, 4, MagicGpat}, 17, 0);
    queue_file(hdr_t'{25, VersionOne, 1, 1, 1, 32'h4750_4155}, 3, 0);
    queue_file(hdr_t'{25, 32'hFFFF_FFFF, 1, 1, 1, MagicGpat}, 3, 0);
    queue_file(hdr_t'{24, VersionOne, 1, 1, 1, MagicGpat}, 3, 0);
    queue_file(hdr_t'{25, VersionOne, 1, 1, 0, MagicGpat}, 3, 0);
    queue_file(hdr_t'{25, VersionOne, 1, 1, 5, MagicGpat}, 0, 0);
    queue_file(hdr_t'{25, VersionOne, 0, 1, 1, MagicGpat}, 3, 0);
    queue_file(hdr_t'{25, VersionOne, 1, 0, 1, MagicGpat}, 3, 0);
    queue_file(hdr_t'{25, VersionOne, 32'h0008_0001, 1, 1, MagicGpat}, 3, 0);
    queue_file(hdr_t'{25, VersionOne, 16384, 16384, 1, MagicGpat}, 40, 0);
    queue_file(hdr_t'{25, VersionOne, 16385, 16384, 1, MagicGpat}, 3, 0);
    queue_file(hdr_t'{25, VersionOne, 1, 1, 1, MagicGpat}, 2, 10);
    queue_file(hdr_t'{25, VersionOne, 1, 1, 1, MagicGpat}, 2, 1);
    queue_file(hdr_t'{32'hFFFF_FFFF, VersionOne, 1, 1, 1, MagicGpat}, 5, 0);
    queue_file(hdr_t'{25, VersionOne, 2, 2, 3, MagicGpat}, 13, 30);
    queue_file(hdr_t'{25, VersionOne, 2, 1, 2, MagicGpat}, 5, 27);
    queue_random_files(250);
    wait_idle();

    // Widest side limit and a pixel limit of 2^40, with a long receiver hold-off to back up the input.
    write_reg(CFG_MAX_SIDE, 41'hFFFF_FFFF);
    write_reg(CFG_MAX_PIXELS, 41'd1099511627776);
    queue_file(hdr_t'{25, VersionOne, 32'hFFFF_FFFF, 1, 4, MagicGpat}, 21, 0);
    queue_file(hdr_t'{25, VersionOne, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, MagicGpat}, 2, 0);
    queue_file(hdr_t'{25, VersionOne, 32'h0010_0000, 32'h0010_0000, 2, MagicGpat}, 9, 0);
    queue_file(hdr_t'{25, VersionOne, 32'h0010_0001, 32'h0010_0000, 2, MagicGpat}, 2, 0);
    queue_random_files(250);
    repeat (40) @(posedge clk_i);
    #1 hold_cycles = 400;
    wait_idle();

    // Narrowest limits: only a single pixel passes.
    write_reg(CFG_MAX_SIDE, 41'd1);
    write_reg(CFG_MAX_PIXELS, 41'd1);
    queue_file(hdr_t'{25, VersionOne, 1, 1, 4, MagicGpat}, 5, 0);
    queue_file(hdr_t'{25, VersionOne, 2, 1, 1, MagicGpat}, 3, 0);
    queue_random_files(200);
    wait_idle();

    // Small random limits so that many ordinary files are too large.
    write_reg(CFG_MAX_SIDE, 41'($urandom_range(2, 6)));
    write_reg(CFG_MAX_PIXELS, 41'($urandom_range(2, 20)));
    queue_random_files(200);
    wait_idle();

    // Back to the reset limits at full rate.
    gaps_on = 1'b0;
    write_reg(CFG_MAX_SIDE, 41'(MaxSideRst));
    write_reg(CFG_MAX_PIXELS, 41'(MaxPixRst));
    queue_random_files(330);
    wait_idle();

    if (expected_rgba.size() != 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", expected_rgba.size());
    end
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
